// ===== src/msh_pkg.sv =====
// Shared opcodes, MessagePack type bytes and the encoded-item descriptor.
`default_nettype none
package msh_pkg;

  localparam int OpWidth    = 3;
  localparam int ValueWidth = 64;
  localparam int ByteWidth  = 8;
  localparam int CountWidth = 4;

  localparam logic [OpWidth-1:0] OP_NULL  = 3'd0;
  localparam logic [OpWidth-1:0] OP_BOOL  = 3'd1;
  localparam logic [OpWidth-1:0] OP_SINT  = 3'd2;
  localparam logic [OpWidth-1:0] OP_UINT  = 3'd3;
  localparam logic [OpWidth-1:0] OP_STR   = 3'd4;
  localparam logic [OpWidth-1:0] OP_ARRAY = 3'd5;
  localparam logic [OpWidth-1:0] OP_MAP   = 3'd6;

  localparam logic [ByteWidth-1:0] MP_NIL    = 8'hC0;
  localparam logic [ByteWidth-1:0] MP_FALSE  = 8'hC2;
  localparam logic [ByteWidth-1:0] MP_TRUE   = 8'hC3;
  localparam logic [ByteWidth-1:0] MP_UINT8  = 8'hCC;
  localparam logic [ByteWidth-1:0] MP_UINT16 = 8'hCD;
  localparam logic [ByteWidth-1:0] MP_UINT32 = 8'hCE;
  localparam logic [ByteWidth-1:0] MP_UINT64 = 8'hCF;
  localparam logic [ByteWidth-1:0] MP_INT8   = 8'hD0;
  localparam logic [ByteWidth-1:0] MP_INT16  = 8'hD1;
  localparam logic [ByteWidth-1:0] MP_INT32  = 8'hD2;
  localparam logic [ByteWidth-1:0] MP_INT64  = 8'hD3;
  localparam logic [ByteWidth-1:0] MP_STR8   = 8'hD9;
  localparam logic [ByteWidth-1:0] MP_STR16  = 8'hDA;
  localparam logic [ByteWidth-1:0] MP_STR32  = 8'hDB;
  localparam logic [ByteWidth-1:0] MP_ARR16  = 8'hDC;
  localparam logic [ByteWidth-1:0] MP_ARR32  = 8'hDD;
  localparam logic [ByteWidth-1:0] MP_MAP16  = 8'hDE;
  localparam logic [ByteWidth-1:0] MP_MAP32  = 8'hDF;
  localparam logic [ByteWidth-1:0] MP_FIXSTR = 8'hA0;
  localparam logic [ByteWidth-1:0] MP_FIXARR = 8'h90;
  localparam logic [ByteWidth-1:0] MP_FIXMAP = 8'h80;

  typedef struct packed {
    logic                  valid;
    logic [ByteWidth-1:0]  type_byte;
    logic [ValueWidth-1:0] payload;
    logic [CountWidth-1:0] nbytes;
  } enc_desc_t;

endpackage
`default_nettype wire

// ===== src/msh_classify.sv =====
// Picks the shortest encoding of one item: type byte, left-aligned payload, byte count.
`default_nettype none
module msh_classify (
  input  wire logic [msh_pkg::OpWidth-1:0]    op,
  input  wire logic [msh_pkg::ValueWidth-1:0] value,
  output msh_pkg::enc_desc_t                  desc
);

  logic signed [msh_pkg::ValueWidth-1:0] sv;
  logic [31:0] len;

  assign sv  = $signed(value);
  assign len = value[31:0];

  function automatic msh_pkg::enc_desc_t mk(
    input logic [msh_pkg::ByteWidth-1:0]  tb,
    input logic [msh_pkg::ValueWidth-1:0] v,
    input logic [msh_pkg::CountWidth-1:0] n
  );
    msh_pkg::enc_desc_t d;
    d.valid     = 1'b1;
    d.type_byte = tb;
    d.nbytes    = n;
    unique case (n)
      4'd1:    d.payload = {v[7:0], 56'h0};
      4'd2:    d.payload = {v[15:0], 48'h0};
      4'd4:    d.payload = {v[31:0], 32'h0};
      4'd8:    d.payload = v;
      default: d.payload = '0;
    endcase
    return d;
  endfunction

  always_comb begin
    desc = '0;
    unique case (op)
      msh_pkg::OP_NULL: desc = mk(msh_pkg::MP_NIL, '0, 4'd0);
      msh_pkg::OP_BOOL: desc = mk(value[0] ? msh_pkg::MP_TRUE : msh_pkg::MP_FALSE, '0, 4'd0);
      msh_pkg::OP_SINT: begin
        priority if (sv >= -64'sd32 && sv <= 64'sd127)
          desc = mk(value[7:0], '0, 4'd0);
        else if (sv >= -64'sd128 && sv < -64'sd32)
          desc = mk(msh_pkg::MP_INT8, value, 4'd1);
        else if (sv >= 64'sd128 && sv <= 64'sd255)
          desc = mk(msh_pkg::MP_UINT8, value, 4'd1);
        else if (sv >= -64'sd32768 && sv <= 64'sd32767)
          desc = mk(msh_pkg::MP_INT16, value, 4'd2);
        else if (sv >= 64'sd32768 && sv <= 64'sd65535)
          desc = mk(msh_pkg::MP_UINT16, value, 4'd2);
        else if (sv >= -64'sd2147483648 && sv <= 64'sd2147483647)
          desc = mk(msh_pkg::MP_INT32, value, 4'd4);
        else if (sv >= 64'sd2147483648 && sv <= 64'sd4294967295)
          desc = mk(msh_pkg::MP_UINT32, value, 4'd4);
        else
          desc = mk(msh_pkg::MP_INT64, value, 4'd8);
      end
      msh_pkg::OP_UINT: begin
        priority if (value < 64'h80)
          desc = mk(value[7:0], '0, 4'd0);
        else if (value < 64'h100)
          desc = mk(msh_pkg::MP_UINT8, value, 4'd1);
        else if (value < 64'h1_0000)
          desc = mk(msh_pkg::MP_UINT16, value, 4'd2);
        else if (value < 64'h1_0000_0000)
          desc = mk(msh_pkg::MP_UINT32, value, 4'd4);
        else
          desc = mk(msh_pkg::MP_UINT64, value, 4'd8);
      end
      msh_pkg::OP_STR: begin
        priority if (len == 32'h0)
          desc = mk(msh_pkg::MP_NIL, '0, 4'd0);
        else if (len < 32'h20)
          desc = mk(msh_pkg::MP_FIXSTR | len[7:0], '0, 4'd0);
        else if (len < 32'h100)
          desc = mk(msh_pkg::MP_STR8, value, 4'd1);
        else if (len < 32'h1_0000)
          desc = mk(msh_pkg::MP_STR16, value, 4'd2);
        else
          desc = mk(msh_pkg::MP_STR32, value, 4'd4);
      end
      msh_pkg::OP_ARRAY: begin
        priority if (len == 32'h0)
          desc = mk(msh_pkg::MP_NIL, '0, 4'd0);
        else if (len < 32'h10)
          desc = mk(msh_pkg::MP_FIXARR | len[7:0], '0, 4'd0);
        else if (len < 32'h1_0000)
          desc = mk(msh_pkg::MP_ARR16, value, 4'd2);
        else
          desc = mk(msh_pkg::MP_ARR32, value, 4'd4);
      end
      msh_pkg::OP_MAP: begin
        priority if (len == 32'h0)
          desc = mk(msh_pkg::MP_NIL, '0, 4'd0);
        else if (len < 32'h10)
          desc = mk(msh_pkg::MP_FIXMAP | len[7:0], '0, 4'd0);
        else if (len < 32'h1_0000)
          desc = mk(msh_pkg::MP_MAP16, value, 4'd2);
        else
          desc = mk(msh_pkg::MP_MAP32, value, 4'd4);
      end
      default: desc = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/msh_serializer.sv =====
// Byte serializer: emits the type byte, then the payload most significant byte first.
`default_nettype none
module msh_serializer (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         load,
  input  wire msh_pkg::enc_desc_t           desc,
  output logic                              ready,
  output logic                              strobe,
  output logic [msh_pkg::ByteWidth-1:0]     out_byte,
  output logic                              last
);

  logic [msh_pkg::ValueWidth-1:0] shreg;
  logic [msh_pkg::CountWidth-1:0] remain;

  assign ready = (remain == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      remain <= '0;
    end else if (load) begin
      strobe   <= 1'b1;
      out_byte <= desc.type_byte;
      last     <= (desc.nbytes == '0);
      shreg    <= desc.payload;
      remain   <= desc.nbytes;
    end else if (remain != '0) begin
      strobe   <= 1'b1;
      out_byte <= shreg[msh_pkg::ValueWidth-1 -: msh_pkg::ByteWidth];
      shreg    <= {shreg[msh_pkg::ValueWidth-msh_pkg::ByteWidth-1:0],
                   {msh_pkg::ByteWidth{1'b0}}};
      last     <= (remain == msh_pkg::CountWidth'(1));
      remain   <= remain - msh_pkg::CountWidth'(1);
    end else begin
      strobe <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== src/msgpack_scalar_header_encoder.sv =====
// Top level: MessagePack scalar and header encoder.
//
// Usage:
//   Present op and value with start high; the transaction is taken at a
//   rising edge where start is high and busy is low. Each item produces a
//   stream of bytes on out_byte, each valid for one cycle with strobe high,
//   type byte first, then the payload most significant byte first; last
//   marks the final byte. An unused op produces no bytes.
//   The item is held in the input register and classified combinationally;
//   its first byte is registered by the serializer once that is ready.
//   Throughput: an item of N bytes (1, 2, 3, 5 or 9) occupies the byte
//   serializer until its last byte; items stream with no gap between them,
//   so a new transaction is taken each cycle while items are single-byte.
//   busy rises while the input register holds an item waiting for the
//   serializer.
//   Reset (synchronous, rst high) drops any held item and in-flight bytes.
//   The receiver cannot stall; every strobe cycle is a delivered byte.
`default_nettype none
module msgpack_scalar_header_encoder (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [msh_pkg::OpWidth-1:0]    op,
  input  wire logic [msh_pkg::ValueWidth-1:0] value,
  output logic                               strobe,
  output logic [msh_pkg::ByteWidth-1:0]      out_byte,
  output logic                               last
);

  logic                           in_valid;
  logic [msh_pkg::OpWidth-1:0]    op_q;
  logic [msh_pkg::ValueWidth-1:0] value_q;
  msh_pkg::enc_desc_t             desc;
  logic                           ser_ready;
  logic                           take;
  logic                           load;

  msh_classify u_classify (
    .op    (op_q),
    .value (value_q),
    .desc  (desc)
  );

  assign take = in_valid && (ser_ready || !desc.valid);
  assign load = in_valid && ser_ready && desc.valid;
  assign busy = in_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (start && !busy) begin
      in_valid <= 1'b1;
      op_q     <= op;
      value_q  <= value;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  msh_serializer u_serializer (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .desc     (desc),
    .ready    (ser_ready),
    .strobe   (strobe),
    .out_byte (out_byte),
    .last     (last)
  );

endmodule
`default_nettype wire

// ===== dv/msgpack_scalar_header_encoder_tb.sv =====
// Self-checking testbench for the MessagePack scalar and header encoder.
`default_nettype none
module msgpack_scalar_header_encoder_tb;

  localparam logic [msh_pkg::OpWidth-1:0] OP_UNUSED = 3'd7;

  typedef struct {
    logic [msh_pkg::OpWidth-1:0]    op;
    logic [msh_pkg::ValueWidth-1:0] value;
  } enc_item_t;

  typedef struct {
    logic [msh_pkg::ByteWidth-1:0] data;
    logic                          last;
  } enc_byte_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic                           busy;
  logic [msh_pkg::OpWidth-1:0]    op = '0;
  logic [msh_pkg::ValueWidth-1:0] value = '0;
  logic                           strobe;
  logic [msh_pkg::ByteWidth-1:0]  out_byte;
  logic                           last;

  enc_item_t pending_items[$];
  enc_byte_t expected_bytes[$];
  enc_byte_t want;
  int        mismatch_count = 0;
  int        gap_left = 0;
  bit        calm = 1'b0;
  logic      took = 1'b0;

  msgpack_scalar_header_encoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .op       (op),
    .value    (value),
    .strobe   (strobe),
    .out_byte (out_byte),
    .last     (last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void queue_encoding(input logic [msh_pkg::OpWidth-1:0] kind,
                                         input logic [msh_pkg::ValueWidth-1:0] operand);
    logic [msh_pkg::ByteWidth-1:0]  head;
    logic [msh_pkg::ValueWidth-1:0] payload;
    logic [31:0]                    len;
    longint                         sv;
    int                             nbytes;
    len = operand[31:0];
    sv = operand;
    payload = operand;
    nbytes = 0;
    head = msh_pkg::MP_NIL;
    case (kind)
      msh_pkg::OP_NULL: head = msh_pkg::MP_NIL;
      msh_pkg::OP_BOOL: head = operand[0] ? msh_pkg::MP_TRUE : msh_pkg::MP_FALSE;
      msh_pkg::OP_SINT: begin
        if (sv >= -32 && sv <= 127) begin
          head = operand[7:0];
        end else if (sv >= -128 && sv < -32) begin
          head = msh_pkg::MP_INT8;
          nbytes = 1;
        end else if (sv >= 128 && sv <= 255) begin
          head = msh_pkg::MP_UINT8;
          nbytes = 1;
        end else if (sv >= -32768 && sv <= 32767) begin
          head = msh_pkg::MP_INT16;
          nbytes = 2;
        end else if (sv >= 32768 && sv <= 65535) begin
          head = msh_pkg::MP_UINT16;
          nbytes = 2;
        end else if (sv >= -64'sd2147483648 && sv <= 64'sd2147483647) begin
          head = msh_pkg::MP_INT32;
          nbytes = 4;
        end else if (sv >= 64'sd2147483648 && sv <= 64'sd4294967295) begin
          head = msh_pkg::MP_UINT32;
          nbytes = 4;
        end else begin
          head = msh_pkg::MP_INT64;
          nbytes = 8;
        end
      end
      msh_pkg::OP_UINT: begin
        if (operand < 64'h80) begin
          head = operand[7:0];
        end else if (operand < 64'h100) begin
          head = msh_pkg::MP_UINT8;
          nbytes = 1;
        end else if (operand < 64'h1_0000) begin
          head = msh_pkg::MP_UINT16;
          nbytes = 2;
        end else if (operand < 64'h1_0000_0000) begin
          head = msh_pkg::MP_UINT32;
          nbytes = 4;
        end else begin
          head = msh_pkg::MP_UINT64;
          nbytes = 8;
        end
      end
      msh_pkg::OP_STR: begin
        payload = {32'd0, len};
        if (len == 0) begin
          head = msh_pkg::MP_NIL;
        end else if (len < 32'h20) begin
          head = msh_pkg::MP_FIXSTR | len[7:0];
        end else if (len < 32'h100) begin
          head = msh_pkg::MP_STR8;
          nbytes = 1;
        end else if (len < 32'h1_0000) begin
          head = msh_pkg::MP_STR16;
          nbytes = 2;
        end else begin
          head = msh_pkg::MP_STR32;
          nbytes = 4;
        end
      end
      msh_pkg::OP_ARRAY, msh_pkg::OP_MAP: begin
        payload = {32'd0, len};
        if (len == 0) begin
          head = msh_pkg::MP_NIL;
        end else if (len < 32'h10) begin
          head = ((kind == msh_pkg::OP_ARRAY) ? msh_pkg::MP_FIXARR : msh_pkg::MP_FIXMAP)
                 | len[7:0];
        end else if (len < 32'h1_0000) begin
          head = (kind == msh_pkg::OP_ARRAY) ? msh_pkg::MP_ARR16 : msh_pkg::MP_MAP16;
          nbytes = 2;
        end else begin
          head = (kind == msh_pkg::OP_ARRAY) ? msh_pkg::MP_ARR32 : msh_pkg::MP_MAP32;
          nbytes = 4;
        end
      end
      default: return;
    endcase
    expected_bytes.push_back('{head, nbytes == 0});
    for (int i = nbytes - 1; i >= 0; i--) begin
      expected_bytes.push_back('{payload[8*i +: 8], i == 0});
    end
  endfunction

  function automatic logic [msh_pkg::ValueWidth-1:0] random_operand();
    logic [msh_pkg::ValueWidth-1:0] edges[13];
    logic [msh_pkg::ValueWidth-1:0] v;
    int                             w;
    edges = '{64'd0, 64'd16, 64'd32, 64'd128, 64'd256, 64'h1_0000, 64'h8000_0000,
              64'h1_0000_0000, 64'h8000_0000_0000_0000, -64'sd32, -64'sd128,
              -64'sd32768, -64'sd2147483648};
    case ($urandom_range(0, 3))
      0: v = {$urandom, $urandom};
      1: begin
        w = $urandom_range(1, 34);
        v = {$urandom, $urandom} & ((64'd1 << w) - 64'd1);
        if ($urandom_range(0, 1) == 1) v = ~v;
      end
      2: v = edges[$urandom_range(0, 12)] + 64'($urandom_range(0, 2)) - 64'd1;
      default: v = {$urandom, 32'($urandom_range(0, 40))};
    endcase
    return v;
  endfunction

  always @(negedge clk) begin
    if (!rst && (!start || took)) begin
      if (start) begin
        if ($urandom_range(0, 31) == 0) calm = !calm;
        gap_left = calm ? 0 : $urandom_range(0, 15);
      end
      if (gap_left == 0 && pending_items.size() > 0) begin
        start <= 1'b1;
        op    <= pending_items[0].op;
        value <= pending_items[0].value;
        void'(pending_items.pop_front());
      end else begin
        start <= 1'b0;
        op    <= msh_pkg::OpWidth'($urandom);
        value <= {$urandom, $urandom};
        if (gap_left > 0) gap_left--;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      took <= 1'b0;
    end else begin
      took <= start && !busy;
      if (start && !busy) queue_encoding(op, value);
      if (strobe) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last=%0b", out_byte, last));
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.data));
          if (last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", last, want.last));
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    pending_items.push_back('{msh_pkg::OP_NULL,  64'hFFFF_FFFF_FFFF_FFFF});
    pending_items.push_back('{msh_pkg::OP_BOOL,  64'd1});
    pending_items.push_back('{msh_pkg::OP_BOOL,  64'hFFFF_FFFF_FFFF_FFFE});
    pending_items.push_back('{msh_pkg::OP_SINT,  64'd127});
    pending_items.push_back('{msh_pkg::OP_SINT,  -64'sd32});
    pending_items.push_back('{msh_pkg::OP_SINT,  -64'sd33});
    pending_items.push_back('{msh_pkg::OP_SINT,  -64'sd128});
    pending_items.push_back('{msh_pkg::OP_SINT,  64'd255});
    pending_items.push_back('{msh_pkg::OP_SINT,  -64'sd129});
    pending_items.push_back('{msh_pkg::OP_SINT,  64'd65535});
    pending_items.push_back('{msh_pkg::OP_SINT,  -64'sd2147483648});
    pending_items.push_back('{msh_pkg::OP_SINT,  64'hFFFF_FFFF});
    pending_items.push_back('{msh_pkg::OP_SINT,  64'h8000_0000_0000_0000});
    pending_items.push_back('{msh_pkg::OP_UINT,  64'd127});
    pending_items.push_back('{msh_pkg::OP_UINT,  64'd255});
    pending_items.push_back('{msh_pkg::OP_UINT,  64'd65535});
    pending_items.push_back('{msh_pkg::OP_UINT,  64'hFFFF_FFFF});
    pending_items.push_back('{msh_pkg::OP_UINT,  64'hFFFF_FFFF_FFFF_FFFF});
    pending_items.push_back('{msh_pkg::OP_STR,   64'hFFFF_FFFF_0000_0000});
    pending_items.push_back('{msh_pkg::OP_STR,   64'd31});
    pending_items.push_back('{msh_pkg::OP_STR,   64'd255});
    pending_items.push_back('{msh_pkg::OP_STR,   64'h1_0000});
    pending_items.push_back('{msh_pkg::OP_ARRAY, 64'd15});
    pending_items.push_back('{msh_pkg::OP_MAP,   64'hFFFF_FFFF_FFFF_FFFF});
    pending_items.push_back('{OP_UNUSED, 64'h1234_5678_9ABC_DEF0});

    repeat (280) begin
      if ($urandom_range(0, 15) == 0)
        pending_items.push_back('{OP_UNUSED, random_operand()});
      else
        pending_items.push_back('{msh_pkg::OpWidth'($urandom_range(0, 6)),
                                  random_operand()});
    end

    while (pending_items.size() != 0 || start) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d items and %0d bytes outstanding",
             pending_items.size(), expected_bytes.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
src/msh_pkg.sv
src/msh_classify.sv
src/msh_serializer.sv
src/msgpack_scalar_header_encoder.sv
dv/msgpack_scalar_header_encoder_tb.sv
